// ===== rtl/sgra_pkg.sv =====
package sgra_pkg;

   // Glyph size in bytes
   localparam int unsigned GLYPH_BYTES = 30;

   // Bank codes
   localparam logic [1:0] BANK_SYMBOL = 2'd0;
   localparam logic [1:0] BANK_KANJI  = 2'd1;
   localparam logic [1:0] BANK_EXTRA  = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_SYMBOL_BASE = 2'd0;
   localparam logic [1:0] REG_KANJI_BASE  = 2'd1;
   localparam logic [1:0] REG_EXTRA_BASE  = 2'd2;

   // Bank code ranges, end exclusive
   localparam logic [15:0] SYM_LO  = 16'h8140;
   localparam logic [15:0] SYM_END = 16'h84BF;
   localparam logic [15:0] EXT_LO  = 16'h8540;
   localparam logic [15:0] EXT_END = 16'h8797;
   localparam logic [15:0] KAN_LO  = 16'h889F;
   localparam logic [15:0] KAN_END = 16'h9873;

   localparam logic [7:0] EXT_RUN_LEAD = 8'h87;

   // Kanji row layout
   localparam logic [7:0]  KANJI_LEAD_FIRST = 8'h88;
   localparam logic [7:0]  TRAIL_LO         = 8'h40;
   localparam logic [7:0]  TRAIL_SPLIT      = 8'h7F;
   localparam logic [7:0]  TRAIL_HIGH       = 8'h9F;
   localparam logic [7:0]  TRAIL_END        = 8'hFD;
   localparam logic [11:0] KANJI_ROW        = 12'd94;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] stop;
      logic [11:0] offset;
   } run_type;

   localparam int unsigned SYM_RUN_COUNT = 19;
   localparam int unsigned EXT_RUN_COUNT = 3;

   localparam run_type SYM_RUNS [SYM_RUN_COUNT] = '{
      '{16'h8140, 16'h817F, 12'h000}, '{16'h8180, 16'h81AD, 12'h03F},
      '{16'h81B8, 16'h81C0, 12'h06C}, '{16'h81C8, 16'h81CF, 12'h074},
      '{16'h81DA, 16'h81E9, 12'h07B}, '{16'h81F0, 16'h81F8, 12'h08A},
      '{16'h81FC, 16'h81FD, 12'h092}, '{16'h824F, 16'h8259, 12'h093},
      '{16'h8260, 16'h827A, 12'h09D}, '{16'h8281, 16'h829B, 12'h0B7},
      '{16'h829F, 16'h82F2, 12'h0D1}, '{16'h8340, 16'h837F, 12'h124},
      '{16'h8380, 16'h8397, 12'h163}, '{16'h839F, 16'h83B7, 12'h17A},
      '{16'h83BF, 16'h83D7, 12'h192}, '{16'h8440, 16'h8461, 12'h1AA},
      '{16'h8470, 16'h847F, 12'h1CB}, '{16'h8480, 16'h8492, 12'h1DA},
      '{16'h849F, 16'h84BF, 12'h1EC}
   };

   localparam run_type EXT_RUNS [EXT_RUN_COUNT] = '{
      '{16'h8740, 16'h875B, 12'h0A0}, '{16'h875C, 16'h8763, 12'h0BB},
      '{16'h8764, 16'h8797, 12'h0C2}
   };

   typedef struct packed {
      logic        found;
      logic [1:0]  bank;
      logic [11:0] glyph_index;
   } decode_type;

   typedef struct packed {
      logic [31:0] symbol_base;
      logic [31:0] kanji_base;
      logic [31:0] extra_base;
   } bank_bases_type;

endpackage

// ===== rtl/sgra_csr.sv =====
module sgra_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_write_data,
   output sgra_pkg::bank_bases_type     bases
);

   sgra_pkg::bank_bases_type bases_ff, bases_in;

   always_comb begin
      bases_in = bases_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sgra_pkg::REG_SYMBOL_BASE: bases_in.symbol_base = csr_write_data;
            sgra_pkg::REG_KANJI_BASE:  bases_in.kanji_base  = csr_write_data;
            sgra_pkg::REG_EXTRA_BASE:  bases_in.extra_base  = csr_write_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bases_ff <= '0;
      end else begin
         bases_ff <= bases_in;
      end
   end

   assign bases = bases_ff;

endmodule

// ===== rtl/sgra_index_decode.sv =====
module sgra_index_decode (
   input  logic [15:0]            char_code,
   output sgra_pkg::decode_type   decode
);

   logic [7:0]  lead;
   logic [7:0]  trail;
   logic [11:0] sym_index;
   logic [11:0] ext_index;
   logic [11:0] kan_index;
   logic        kan_half;
   logic [4:0]  lead_off;
   logic [5:0]  kan_row;
   logic [11:0] kan_col;

   assign lead  = char_code[15:8];
   assign trail = char_code[7:0];

   // Symbol runs are disjoint, so OR together the hit values
   always_comb begin
      sym_index = '0;
      for (int i = 0; i < sgra_pkg::SYM_RUN_COUNT; i++) begin
         if (char_code >= sgra_pkg::SYM_RUNS[i].start &&
             char_code <  sgra_pkg::SYM_RUNS[i].stop) begin
            sym_index = sym_index |
                        (12'(char_code - sgra_pkg::SYM_RUNS[i].start) +
                         sgra_pkg::SYM_RUNS[i].offset);
         end
      end
   end

   // Leads 0x85 and 0x86 are dense; lead 0x87 goes through its runs
   always_comb begin
      ext_index = '0;
      if (lead == sgra_pkg::EXT_RUN_LEAD) begin
         for (int i = 0; i < sgra_pkg::EXT_RUN_COUNT; i++) begin
            if (char_code >= sgra_pkg::EXT_RUNS[i].start &&
                char_code <  sgra_pkg::EXT_RUNS[i].stop) begin
               ext_index = ext_index |
                           (12'(char_code - sgra_pkg::EXT_RUNS[i].start) +
                            sgra_pkg::EXT_RUNS[i].offset);
            end
         end
      end else begin
         ext_index = 12'(char_code - sgra_pkg::EXT_LO);
      end
   end

   // Kanji: two half rows of 94 per lead byte. Trails 0x80-0x9E sit below the
   // upper half row start, so the column goes negative and wraps at 12 bits.
   assign kan_half = (trail >= sgra_pkg::TRAIL_SPLIT);
   assign lead_off = 5'(lead - sgra_pkg::KANJI_LEAD_FIRST);
   assign kan_row  = {lead_off, 1'b0} + 6'(kan_half) - 6'd1;
   assign kan_col  = {4'd0, trail} -
                     {4'd0, (kan_half ? sgra_pkg::TRAIL_HIGH : sgra_pkg::TRAIL_LO)};

   always_comb begin
      if (trail < sgra_pkg::TRAIL_LO || trail == sgra_pkg::TRAIL_SPLIT ||
          trail >= sgra_pkg::TRAIL_END) begin
         kan_index = '0;
      end else begin
         kan_index = kan_col + 12'(kan_row) * sgra_pkg::KANJI_ROW;
      end
   end

   always_comb begin
      decode = '0;
      priority if (char_code >= sgra_pkg::SYM_LO && char_code < sgra_pkg::SYM_END) begin
         decode.found       = 1'b1;
         decode.bank        = sgra_pkg::BANK_SYMBOL;
         decode.glyph_index = sym_index;
      end else if (char_code >= sgra_pkg::EXT_LO && char_code < sgra_pkg::EXT_END) begin
         decode.found       = 1'b1;
         decode.bank        = sgra_pkg::BANK_EXTRA;
         decode.glyph_index = ext_index;
      end else if (char_code >= sgra_pkg::KAN_LO && char_code < sgra_pkg::KAN_END) begin
         decode.found       = 1'b1;
         decode.bank        = sgra_pkg::BANK_KANJI;
         decode.glyph_index = kan_index;
      end else begin
         decode = '0;
      end
   end

endmodule

// ===== rtl/sjis_glyph_rom_address.sv =====
// An accepted code passes through the input register, the index register and the result
// register, in that order, before its result appears on rsp_valid.
// Throughput: one transaction per cycle; the three stages advance independently,
// so req_stall only rises when every stage is full and rsp_stall holds the output.
// Reset: synchronous, active high; clears all stage valids and the three bank bases.
module sjis_glyph_rom_address (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_char_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [1:0]  rsp_bank,
   output logic [11:0] rsp_glyph_index,
   output logic [31:0] rsp_glyph_address,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   sgra_pkg::bank_bases_type bases;
   sgra_pkg::decode_type     decode;

   // Stage advance flags: a stage may load when empty or when it drains this cycle
   logic adv1, adv2, adv3;

   // Stage 1: registered character code
   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_code_ff;

   // Stage 2: decoded index and the base of its bank
   logic                 s2_valid_ff, s2_valid_in;
   sgra_pkg::decode_type s2_decode_ff;
   logic [31:0]          s2_base_ff, s2_base_in;

   // Stage 3: result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff;
   logic [1:0]  rsp_bank_ff;
   logic [11:0] rsp_index_ff;
   logic [31:0] rsp_address_ff, rsp_address_in;

   sgra_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .bases            (bases)
   );

   sgra_index_decode u_decode (
      .char_code (s1_code_ff),
      .decode    (decode)
   );

   assign adv3 = !rsp_valid_ff || !rsp_stall;
   assign adv2 = !s2_valid_ff  || adv3;
   assign adv1 = !s1_valid_ff  || adv2;

   // Hold the requester off only when the whole pipe is full and blocked
   assign req_stall = !adv1;

   assign s1_valid_in  = adv1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = adv3 ? s2_valid_ff : rsp_valid_ff;

   // Pick the bank base alongside the index; change bases only while idle (not enforced here)
   always_comb begin
      unique case (decode.bank)
         sgra_pkg::BANK_SYMBOL: s2_base_in = bases.symbol_base;
         sgra_pkg::BANK_KANJI:  s2_base_in = bases.kanji_base;
         sgra_pkg::BANK_EXTRA:  s2_base_in = bases.extra_base;
         default:               s2_base_in = '0;
      endcase
   end

   // Base plus index times glyph size, wrapping at 32 bits; zero when not found
   assign rsp_address_in = s2_decode_ff.found
                         ? s2_base_ff + 32'(s2_decode_ff.glyph_index) * 32'(sgra_pkg::GLYPH_BYTES)
                         : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_code_ff <= req_char_code;
      end
      if (adv2) begin
         s2_decode_ff <= decode;
         s2_base_ff   <= s2_base_in;
      end
      if (adv3) begin
         rsp_found_ff   <= s2_decode_ff.found;
         rsp_bank_ff    <= s2_decode_ff.bank;
         rsp_index_ff   <= s2_decode_ff.glyph_index;
         rsp_address_ff <= rsp_address_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_bank          = rsp_bank_ff;
   assign rsp_glyph_index   = rsp_index_ff;
   assign rsp_glyph_address = rsp_address_ff;

   // A stall to the requester means every stage holds a transaction
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req_stall raised with room in the pipe");

   // An accepted transaction lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction lost at stage 1");

   // A stage 2 transaction moves to the output when the output drains
   a_s2_moves: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && adv3) |=> rsp_valid_ff)
      else $error("stage 2 transaction lost before output");

   // Not found gives all-zero fields
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_bank == 2'd0 && rsp_glyph_index == 12'd0 && rsp_glyph_address == 32'd0))
      else $error("not-found result carries non-zero fields");

   // A found result names one of the three banks
   a_bank_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_bank == sgra_pkg::BANK_SYMBOL || rsp_bank == sgra_pkg::BANK_KANJI ||
          rsp_bank == sgra_pkg::BANK_EXTRA))
      else $error("found result with illegal bank code");

endmodule

// ===== tb/tb_sjis_glyph_rom_address.sv =====
typedef struct packed {
   logic [15:0] first;
   logic [15:0] limit;
   logic [11:0] base;
} glyph_run_type;

typedef struct packed {
   logic [15:0] char_code;
   logic        found;
   logic [1:0]  bank;
   logic [11:0] glyph_index;
   logic [31:0] glyph_address;
} glyph_lookup_type;

class glyph_address_scoreboard;
   glyph_lookup_type pending[$];
   logic [31:0]      symbol_base;
   logic [31:0]      kanji_base;
   logic [31:0]      extra_base;
   int unsigned      errors;

   function new();
      symbol_base = '0;
      kanji_base  = '0;
      extra_base  = '0;
      errors      = 0;
   endfunction

   function void write_base(logic [1:0] index, logic [31:0] value);
      case (index)
         sgra_pkg::REG_SYMBOL_BASE: symbol_base = value;
         sgra_pkg::REG_KANJI_BASE:  kanji_base  = value;
         sgra_pkg::REG_EXTRA_BASE:  extra_base  = value;
         default: ;
      endcase
   endfunction

   function glyph_run_type symbol_run(int n);
      case (n)
         0:  symbol_run = {16'h8140, 16'h817F, 12'h000};
         1:  symbol_run = {16'h8180, 16'h81AD, 12'h03F};
         2:  symbol_run = {16'h81B8, 16'h81C0, 12'h06C};
         3:  symbol_run = {16'h81C8, 16'h81CF, 12'h074};
         4:  symbol_run = {16'h81DA, 16'h81E9, 12'h07B};
         5:  symbol_run = {16'h81F0, 16'h81F8, 12'h08A};
         6:  symbol_run = {16'h81FC, 16'h81FD, 12'h092};
         7:  symbol_run = {16'h824F, 16'h8259, 12'h093};
         8:  symbol_run = {16'h8260, 16'h827A, 12'h09D};
         9:  symbol_run = {16'h8281, 16'h829B, 12'h0B7};
         10: symbol_run = {16'h829F, 16'h82F2, 12'h0D1};
         11: symbol_run = {16'h8340, 16'h837F, 12'h124};
         12: symbol_run = {16'h8380, 16'h8397, 12'h163};
         13: symbol_run = {16'h839F, 16'h83B7, 12'h17A};
         14: symbol_run = {16'h83BF, 16'h83D7, 12'h192};
         15: symbol_run = {16'h8440, 16'h8461, 12'h1AA};
         16: symbol_run = {16'h8470, 16'h847F, 12'h1CB};
         17: symbol_run = {16'h8480, 16'h8492, 12'h1DA};
         default: symbol_run = {16'h849F, 16'h84BF, 12'h1EC};
      endcase
   endfunction

   function glyph_run_type extra_run(int n);
      case (n)
         0:  extra_run = {16'h8740, 16'h875B, 12'h0A0};
         1:  extra_run = {16'h875C, 16'h8763, 12'h0BB};
         default: extra_run = {16'h8764, 16'h8797, 12'h0C2};
      endcase
   endfunction

   // Runs are searched in order; a code in no run falls into a gap.
   function int unsigned run_index(logic [15:0] code, bit in_symbols);
      glyph_run_type r;
      int unsigned   count;
      count = in_symbols ? 19 : 3;
      for (int n = 0; n < count; n++) begin
         r = in_symbols ? symbol_run(n) : extra_run(n);
         if (code >= r.first && code < r.limit)
            return int'(code) - int'(r.first) + int'(r.base);
      end
      return 0;
   endfunction

   // Two rows of 94 per lead byte, the first row of lead 0x88 absent.
   function int unsigned kanji_index(logic [15:0] code);
      logic [7:0] lead;
      logic [7:0] trail;
      int         upper;
      int         row;
      int         row_start;
      lead  = code[15:8];
      trail = code[7:0];
      if (trail < 8'h40 || trail == 8'h7F || trail >= 8'hFD)
         return 0;
      upper     = (trail > 8'h7F) ? 1 : 0;
      row       = (int'(lead) - 'h88) * 2 + upper - 1;
      row_start = int'({lead, (upper != 0) ? 8'h9F : 8'h40});
      return int'(code) - row_start + 94 * row;
   endfunction

   function glyph_lookup_type lookup(logic [15:0] code);
      glyph_lookup_type e;
      int unsigned      idx;
      logic [31:0]      base;
      e           = '0;
      e.char_code = code;
      idx         = 0;
      base        = '0;
      if (code >= 16'h8140 && code < 16'h84BF) begin
         e.found = 1'b1;
         e.bank  = sgra_pkg::BANK_SYMBOL;
         base    = symbol_base;
         idx     = run_index(code, 1'b1);
      end else if (code >= 16'h8540 && code < 16'h8797) begin
         e.found = 1'b1;
         e.bank  = sgra_pkg::BANK_EXTRA;
         base    = extra_base;
         idx     = (code[15:8] == 8'h87) ? run_index(code, 1'b0) : int'(code) - 'h8540;
      end else if (code >= 16'h889F && code < 16'h9873) begin
         e.found = 1'b1;
         e.bank  = sgra_pkg::BANK_KANJI;
         base    = kanji_base;
         idx     = kanji_index(code);
      end
      e.glyph_index = idx[11:0];
      if (e.found)
         e.glyph_address = base + idx[11:0] * sgra_pkg::GLYPH_BYTES;
      return e;
   endfunction

   function void note_code(logic [15:0] code);
      pending.push_back(lookup(code));
   endfunction

   function void compare_field(string name, logic [15:0] code, logic [31:0] want,
                               logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch for code %h: expected %h, actual %h",
                  $time, name, code, want, got);
         errors++;
      end
   endfunction

   function void check_result(logic found, logic [1:0] bank, logic [11:0] glyph_index,
                              logic [31:0] glyph_address);
      glyph_lookup_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual %b %h %h %h",
                  $time, found, bank, glyph_index, glyph_address);
         errors++;
         return;
      end
      e = pending.pop_front();
      compare_field("found", e.char_code, 32'(e.found), 32'(found));
      compare_field("bank", e.char_code, 32'(e.bank), 32'(bank));
      compare_field("glyph_index", e.char_code, 32'(e.glyph_index), 32'(glyph_index));
      compare_field("glyph_address", e.char_code, e.glyph_address, glyph_address);
   endfunction
endclass

module tb_sjis_glyph_rom_address;

   // One write to a register index outside the list, which must be ignored
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam int unsigned CODES_PER_PHASE = 265;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_char_code;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [1:0]  rsp_bank;
   logic [11:0] rsp_glyph_index;
   logic [31:0] rsp_glyph_address;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   glyph_address_scoreboard glyphs;
   int unsigned             cycle_count = 0;
   // Set for a whole phase to give a long stretch with neither side idling
   bit                      calm = 1'b0;

   // Range edges, run gaps, the unmatched 0x84 trail and the kanji trail gaps
   logic [15:0] boundary_codes[$] = '{
      16'h0000, 16'hFFFF, 16'h813F, 16'h8140, 16'h817E, 16'h817F, 16'h81FC,
      16'h8462, 16'h84BE, 16'h84BF, 16'h853F, 16'h8540, 16'h86FF, 16'h8740,
      16'h875B, 16'h8796, 16'h8797, 16'h889E, 16'h889F, 16'h88FC, 16'h8930,
      16'h897F, 16'h89FD, 16'h9872, 16'h9873
   };

   sjis_glyph_rom_address dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_bank          (rsp_bank),
      .rsp_glyph_index   (rsp_glyph_index),
      .rsp_glyph_address (rsp_glyph_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abandon the run if it hangs; the limit is far beyond the slowest good run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL sjis_glyph_rom_address");
         $finish;
      end
   end

   // Back-pressure on the result side: stall at random with a probability of about 31 percent
   always @(negedge clock) begin
      rsp_stall = !reset && !calm && ($urandom_range(99) < 31);
   end

   // Check every result transaction as it is taken at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         glyphs.check_result(rsp_found, rsp_bank, rsp_glyph_index, rsp_glyph_address);
   end

   // Offer one code and hold it until the block takes it. Entered and left at a
   // falling edge; req_valid stays high on return so back-to-back codes flow.
   task automatic send_code(input logic [15:0] code);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_char_code = code;
      do @(posedge clock); while (req_stall);
      glyphs.note_code(code);
      @(negedge clock);
   endtask

   // Mostly codes inside or just around the three banks, the rest anywhere
   function automatic logic [15:0] random_code();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25)
         return 16'($urandom_range(16'h84C0, 16'h8138));
      else if (pick < 40)
         return 16'($urandom_range(16'h8798, 16'h853E));
      else if (pick < 75)
         return {8'($urandom_range(8'h98, 8'h88)), 8'($urandom_range(8'hFF))};
      else
         return 16'($urandom_range(16'hFFFF));
   endfunction

   task automatic send_random_codes(input int unsigned count);
      repeat (count) send_code(random_code());
      req_valid = 1'b0;
   endtask

   // Drop the request, drain every outstanding result, then let the pipe empty
   task automatic settle();
      req_valid = 1'b0;
      while (glyphs.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one bank base; called only with the block idle, at a falling edge
   task automatic write_bank_base(input logic [1:0] index, input logic [31:0] value);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      glyphs.write_base(index, value);
   endtask

   task automatic write_all_bases(input logic [31:0] symbol_value,
                                  input logic [31:0] kanji_value,
                                  input logic [31:0] extra_value);
      write_bank_base(sgra_pkg::REG_SYMBOL_BASE, symbol_value);
      write_bank_base(sgra_pkg::REG_KANJI_BASE, kanji_value);
      write_bank_base(sgra_pkg::REG_EXTRA_BASE, extra_value);
   endtask

   initial begin
      glyphs           = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = sgra_pkg::REG_SYMBOL_BASE;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Bases at their reset value: the edge codes, then random codes
      foreach (boundary_codes[i]) send_code(boundary_codes[i]);
      send_random_codes(CODES_PER_PHASE);
      settle();

      // All bases at the top of the range, so nearly every address wraps
      write_all_bases('1, '1, '1);
      send_random_codes(CODES_PER_PHASE);
      settle();

      // Random bases and a write to the unused index; no idling on either side
      write_all_bases($urandom, $urandom, $urandom);
      write_bank_base(REG_UNUSED, $urandom);
      calm = 1'b1;
      send_random_codes(CODES_PER_PHASE);
      settle();
      calm = 1'b0;

      // Bases back to zero by explicit writes
      write_all_bases('0, '0, '0);
      send_random_codes(CODES_PER_PHASE);
      settle();

      // Mixed extremes: one bank just short of the wrap point
      write_all_bases(32'hFFFF_FFE2, 32'h0000_0000, $urandom);
      send_random_codes(CODES_PER_PHASE);
      settle();

      if (glyphs.errors == 0)
         $display("PASS sjis_glyph_rom_address");
      else
         $display("FAIL sjis_glyph_rom_address");
      $finish;
   end

endmodule

// ===== sjis_glyph_rom_address.f =====
rtl/sgra_pkg.sv
rtl/sgra_csr.sv
rtl/sgra_index_decode.sv
rtl/sjis_glyph_rom_address.sv
tb/tb_sjis_glyph_rom_address.sv
